// ===== design/dirty_range_coalescer_unit_assert.svh =====
// Assertion macros used by the dirty range coalescer controller (drc_ctrl).
// Each macro expects signals named clk and arst_n in the scope where it is used.
`ifndef DIRTY_RANGE_COALESCER_UNIT_ASSERT_SVH
`define DIRTY_RANGE_COALESCER_UNIT_ASSERT_SVH

// Checked on every rising edge, held off while reset is asserted.
`define DRC_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checked on every rising edge, including during reset.
`define DRC_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/drc_pkg.sv =====
// Shared types for the dirty range coalescer: result kinds, controller states,
// and the command and status structs between controller and datapath. No dependencies.
package drc_pkg;

	typedef enum logic [2:0] {
		KIND_MERGED   = 3'd0,
		KIND_APPENDED = 3'd1,
		KIND_FULL     = 3'd2,
		KIND_RANGE    = 3'd3,
		KIND_FLUSHED  = 3'd4
	} kind_t;

	typedef enum logic [1:0] {
		SRC_ECHO   = 2'd0,
		SRC_MERGE  = 2'd1,
		SRC_STORED = 2'd2
	} src_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_W_READ,
		ST_W_CMP,
		ST_W_DECIDE,
		ST_W_END,
		ST_F_READ,
		ST_F_EMIT
	} state_t;

	typedef struct packed {
		logic  accept;
		logic  idx_clr;
		logic  idx_inc;
		logic  rd_en;
		logic  cmp_load;
		logic  wr_merge;
		logic  wr_append;
		logic  cnt_clr;
		logic  emit;
		kind_t emit_kind;
		src_t  emit_src;
		logic  emit_last;
	} cmd_t;

	typedef struct packed {
		logic is_flush;
		logic over_range;
		logic idx_at_count;
		logic count_zero;
		logic count_full;
		logic match;
		logic len_over;
		logic out_free;
		logic flush_last;
	} status_t;

endpackage

// ===== design/drc_datapath.sv =====
// Datapath of the dirty range coalescer: range table memory, item registers,
// overlap compare, merge arithmetic and the result register. Uses drc_pkg.
module drc_datapath
	import drc_pkg::*;
#(
	parameter int MAX_RANGES = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        operation,
	input  logic [31:0] write_offset,
	input  logic [31:0] write_size,
	input  logic        out_stall,
	output logic        out_valid,
	output logic [2:0]  kind,
	output logic [31:0] range_offset,
	output logic [31:0] range_size,
	output logic        last,
	input  cmd_t        cmd,
	output status_t     sts
);

	localparam int CW = $clog2(MAX_RANGES + 1);
	localparam int IW = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;

	logic [31:0] start_mem [MAX_RANGES];
	logic [31:0] len_mem   [MAX_RANGES];

	logic          op_q;
	logic [31:0]   off_q;
	logic [31:0]   size_q;
	logic [32:0]   end_q;
	logic [CW-1:0] count_q;
	logic [CW-1:0] idx_q;
	logic [31:0]   rd_start_q;
	logic [31:0]   rd_len_q;
	logic          match_q;
	logic [31:0]   lo_q;
	logic [32:0]   hi_q;
	logic          out_valid_q;
	logic [2:0]    kind_q;
	logic [31:0]   offset_q;
	logic [31:0]   size_out_q;
	logic          last_q;

	logic [32:0]   stored_end;
	logic          cmp_match;
	logic [31:0]   cmp_lo;
	logic [32:0]   cmp_hi;
	logic [32:0]   merge_len;
	logic [IW-1:0] idx_addr;
	logic [IW-1:0] cnt_addr;
	logic [31:0]   emit_off;
	logic [31:0]   emit_size;

	assign idx_addr   = idx_q[IW-1:0];
	assign cnt_addr   = count_q[IW-1:0];
	assign stored_end = {1'b0, rd_start_q} + {1'b0, rd_len_q};
	assign cmp_match  = ({1'b0, off_q} <= stored_end) && (end_q >= {1'b0, rd_start_q});
	assign cmp_lo     = (off_q < rd_start_q) ? off_q : rd_start_q;
	assign cmp_hi     = (end_q > stored_end) ? end_q : stored_end;
	assign merge_len  = hi_q - {1'b0, lo_q};

	always_comb begin
		case (cmd.emit_src)
			SRC_ECHO: begin
				emit_off  = off_q;
				emit_size = size_q;
			end
			SRC_MERGE: begin
				emit_off  = lo_q;
				emit_size = merge_len[31:0];
			end
			SRC_STORED: begin
				emit_off  = rd_start_q;
				emit_size = rd_len_q;
			end
			default: begin
				emit_off  = off_q;
				emit_size = size_q;
			end
		endcase
	end

	always_comb begin
		sts.is_flush     = op_q;
		sts.over_range   = end_q[32] && (end_q[31:0] != 32'd0);
		sts.idx_at_count = (idx_q == count_q);
		sts.count_zero   = (count_q == '0);
		sts.count_full   = (count_q == CW'(MAX_RANGES));
		sts.match        = match_q;
		sts.len_over     = merge_len[32];
		sts.out_free     = !out_valid_q || !out_stall;
		sts.flush_last   = ((idx_q + CW'(1)) == count_q);
	end

	always_ff @(posedge clk) begin
		if (cmd.wr_merge) begin
			start_mem[idx_addr] <= lo_q;
			len_mem[idx_addr]   <= merge_len[31:0];
		end else if (cmd.wr_append) begin
			start_mem[cnt_addr] <= off_q;
			len_mem[cnt_addr]   <= size_q;
		end
		if (cmd.rd_en) begin
			rd_start_q <= start_mem[idx_addr];
			rd_len_q   <= len_mem[idx_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			op_q   <= operation;
			off_q  <= write_offset;
			size_q <= write_size;
			end_q  <= {1'b0, write_offset} + {1'b0, write_size};
		end
		if (cmd.cmp_load) begin
			match_q <= cmp_match;
			lo_q    <= cmp_lo;
			hi_q    <= cmp_hi;
		end
		if (cmd.emit) begin
			kind_q     <= cmd.emit_kind;
			offset_q   <= emit_off;
			size_out_q <= emit_size;
			last_q     <= cmd.emit_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.cnt_clr) begin
				count_q <= '0;
			end else if (cmd.wr_append) begin
				count_q <= count_q + CW'(1);
			end
			if (cmd.idx_clr) begin
				idx_q <= '0;
			end else if (cmd.idx_inc) begin
				idx_q <= idx_q + CW'(1);
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign kind         = kind_q;
	assign range_offset = offset_q;
	assign range_size   = size_out_q;
	assign last         = last_q;

endmodule

// ===== design/drc_ctrl.sv =====
// Controller of the dirty range coalescer: sequences the table scan, merge,
// append and flush. Uses drc_pkg and dirty_range_coalescer_unit_assert.svh.
`include "dirty_range_coalescer_unit_assert.svh"

module drc_ctrl
	import drc_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_stall,
	input  status_t sts,
	output cmd_t    cmd
);

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) state_d = ST_CHECK;
			end
			ST_CHECK: begin
				if (sts.is_flush) begin
					state_d = sts.count_zero ? ST_IDLE : ST_F_READ;
				end else if (sts.over_range) begin
					if (sts.out_free) state_d = ST_IDLE;
				end else begin
					state_d = ST_W_READ;
				end
			end
			ST_W_READ: begin
				state_d = sts.idx_at_count ? ST_W_END : ST_W_CMP;
			end
			ST_W_CMP: begin
				state_d = ST_W_DECIDE;
			end
			ST_W_DECIDE: begin
				if (!sts.match) begin
					state_d = ST_W_READ;
				end else if (sts.out_free) begin
					state_d = ST_IDLE;
				end
			end
			ST_W_END: begin
				if (sts.out_free) state_d = ST_IDLE;
			end
			ST_F_READ: begin
				state_d = ST_F_EMIT;
			end
			ST_F_EMIT: begin
				if (sts.out_free) state_d = sts.flush_last ? ST_IDLE : ST_F_READ;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd           = '0;
		cmd.emit_kind = KIND_MERGED;
		cmd.emit_src  = SRC_ECHO;
		cmd.emit_last = 1'b1;
		in_stall      = (state_q != ST_IDLE);
		case (state_q)
			ST_IDLE: begin
				cmd.accept  = in_valid;
				cmd.idx_clr = in_valid;
			end
			ST_CHECK: begin
				if (!sts.is_flush && sts.over_range && sts.out_free) begin
					cmd.emit      = 1'b1;
					cmd.emit_kind = KIND_RANGE;
				end
			end
			ST_W_READ: begin
				cmd.rd_en = !sts.idx_at_count;
			end
			ST_W_CMP: begin
				cmd.cmp_load = 1'b1;
			end
			ST_W_DECIDE: begin
				if (!sts.match) begin
					cmd.idx_inc = 1'b1;
				end else if (sts.out_free) begin
					cmd.emit = 1'b1;
					if (sts.len_over) begin
						cmd.emit_kind = KIND_RANGE;
					end else begin
						cmd.emit_kind = KIND_MERGED;
						cmd.emit_src  = SRC_MERGE;
						cmd.wr_merge  = 1'b1;
					end
				end
			end
			ST_W_END: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					if (sts.count_full) begin
						cmd.emit_kind = KIND_FULL;
					end else begin
						cmd.emit_kind = KIND_APPENDED;
						cmd.wr_append = 1'b1;
					end
				end
			end
			ST_F_READ: begin
				cmd.rd_en = 1'b1;
			end
			ST_F_EMIT: begin
				if (sts.out_free) begin
					cmd.emit      = 1'b1;
					cmd.emit_kind = KIND_FLUSHED;
					cmd.emit_src  = SRC_STORED;
					cmd.emit_last = sts.flush_last;
					cmd.cnt_clr   = sts.flush_last;
					cmd.idx_inc   = !sts.flush_last;
				end
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	`DRC_ASSERT(a_emit_when_free, cmd.emit |-> sts.out_free, "Beat emitted while the output register is occupied.")
	`DRC_ASSERT(a_append_not_full, cmd.wr_append |-> !sts.count_full, "Append into a full range table.")
	`DRC_ASSERT(a_merge_valid, cmd.wr_merge |-> (sts.match && !sts.len_over), "Merge written without a valid match.")
	`DRC_ASSERT(a_clear_on_last, cmd.cnt_clr |-> (cmd.emit && sts.flush_last), "Table cleared before the final flush beat.")

endmodule

// ===== design/dirty_range_coalescer_unit.sv =====
// Dirty range coalescer top level. A write is compared with the stored ranges in table order and
// merges with the first one it overlaps or touches; an append or a full reject follows a scan of
// all stored ranges, and an out-of-range write is rejected without a scan.
// A flush reads and emits the stored ranges one by one; output stalls hold the controller.
// One item is in work at a time; the next is accepted the cycle after its last beat is loaded.
// Reset clears the range count, controller state and output valid; table contents are not cleared.
module dirty_range_coalescer_unit
	import drc_pkg::*;
#(
	parameter int MAX_RANGES = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        operation,
	input  logic [31:0] write_offset,
	input  logic [31:0] write_size,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  kind,
	output logic [31:0] range_offset,
	output logic [31:0] range_size,
	output logic        last
);

	cmd_t    cmd;
	status_t sts;

	drc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	drc_datapath #(
		.MAX_RANGES (MAX_RANGES)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.operation    (operation),
		.write_offset (write_offset),
		.write_size   (write_size),
		.out_stall    (out_stall),
		.out_valid    (out_valid),
		.kind         (kind),
		.range_offset (range_offset),
		.range_size   (range_size),
		.last         (last),
		.cmd          (cmd),
		.sts          (sts)
	);

endmodule

// ===== tb/drc_checker.sv =====
// Checker for the dirty range coalescer: watches both channels, keeps its own copy of the
// range table, and compares every result beat with the oldest predicted one.
// Depends on drc_pkg for the result kinds.
module drc_checker
	import drc_pkg::*;
#(
	parameter int   TABLE_DEPTH = 16,
	parameter logic FLUSH_OP    = 1'b1
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic        operation,
	input  logic [31:0] write_offset,
	input  logic [31:0] write_size,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [2:0]  kind,
	input  logic [31:0] range_offset,
	input  logic [31:0] range_size,
	input  logic        last,
	output int          failures,
	output int          pending,
	output int          beats_checked
);

	typedef struct packed {
		kind_t       kind;
		logic [31:0] offset;
		logic [31:0] size;
		logic        last;
	} range_beat_t;

	localparam logic [32:0] SPAN_END = 33'h1_0000_0000;

	logic [31:0] tbl_start [TABLE_DEPTH];
	logic [31:0] tbl_len [TABLE_DEPTH];
	int tbl_count;
	range_beat_t expected_ranges [$];

	function automatic range_beat_t make_beat(kind_t k, logic [31:0] off, logic [31:0] sz,
			logic lst);
		range_beat_t b;
		b.kind = k;
		b.offset = off;
		b.size = sz;
		b.last = lst;
		return b;
	endfunction

	task automatic queue_beat(input range_beat_t b);
		expected_ranges.insert(expected_ranges.size(), b);
	endtask

	task automatic apply_to_table(input logic op, input logic [31:0] off,
			input logic [31:0] sz);
		logic [32:0] w_end, r_end, lo, hi, span;
		int hit;
		hit = -1;
		if (op == FLUSH_OP) begin
			for (int i = 0; i < tbl_count; i++)
				queue_beat(make_beat(KIND_FLUSHED, tbl_start[i], tbl_len[i],
					i == tbl_count - 1));
			tbl_count = 0;
		end else begin
			w_end = {1'b0, off} + {1'b0, sz};
			if (w_end > SPAN_END) begin
				queue_beat(make_beat(KIND_RANGE, off, sz, 1'b1));
			end else begin
				for (int i = 0; i < tbl_count; i++) begin
					r_end = {1'b0, tbl_start[i]} + {1'b0, tbl_len[i]};
					if (hit < 0 && {1'b0, off} <= r_end && w_end >= {1'b0, tbl_start[i]})
						hit = i;
				end
				if (hit >= 0) begin
					r_end = {1'b0, tbl_start[hit]} + {1'b0, tbl_len[hit]};
					lo = (off < tbl_start[hit]) ? {1'b0, off} : {1'b0, tbl_start[hit]};
					hi = (w_end > r_end) ? w_end : r_end;
					span = hi - lo;
					if (span >= SPAN_END) begin
						queue_beat(make_beat(KIND_RANGE, off, sz, 1'b1));
					end else begin
						tbl_start[hit] = lo[31:0];
						tbl_len[hit] = span[31:0];
						queue_beat(make_beat(KIND_MERGED, lo[31:0], span[31:0], 1'b1));
					end
				end else if (tbl_count >= TABLE_DEPTH) begin
					queue_beat(make_beat(KIND_FULL, off, sz, 1'b1));
				end else begin
					tbl_start[tbl_count] = off;
					tbl_len[tbl_count] = sz;
					tbl_count++;
					queue_beat(make_beat(KIND_APPENDED, off, sz, 1'b1));
				end
			end
		end
	endtask

	task automatic check_beat();
		range_beat_t want;
		if (expected_ranges.size() == 0) begin
			if (failures < 10)
				$display("Unexpected result beat at %0t: kind %0d offset %h size %h last %b",
					$time, kind, range_offset, range_size, last);
			failures <= failures + 1;
		end else begin
			want = expected_ranges.pop_front();
			if (kind !== want.kind || range_offset !== want.offset ||
					range_size !== want.size || last !== want.last) begin
				if (failures < 10) begin
					$display("Mismatch at %0t: expected kind %0d offset %h size %h last %b",
						$time, want.kind, want.offset, want.size, want.last);
					$display("    actual kind %0d offset %h size %h last %b",
						kind, range_offset, range_size, last);
				end
				failures <= failures + 1;
			end
		end
		beats_checked <= beats_checked + 1;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tbl_count = 0;
			expected_ranges.delete();
			failures <= 0;
			pending <= 0;
			beats_checked <= 0;
		end else begin
			if (out_valid && !out_stall)
				check_beat();
			if (in_valid && !in_stall)
				apply_to_table(operation, write_offset, write_size);
			pending <= expected_ranges.size();
		end
	end

endmodule

// ===== tb/tb.sv =====
// Top of the dirty range coalescer testbench: clock, reset, write and flush stimulus,
// random output stalls, and the final verdict.
// Depends on dirty_range_coalescer_unit and drc_checker.
module tb;

	localparam int   TABLE_DEPTH  = 16;
	localparam logic OP_WRITE     = 1'b0;
	localparam logic OP_FLUSH     = 1'b1;
	localparam int   CYCLE_LIMIT  = 400000;
	localparam int   DRAIN_CYCLES = 64;
	localparam int   HOLD_CYCLES  = 300;
	localparam int   RANDOM_ITEMS = 320;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic        operation;
	logic [31:0] write_offset;
	logic [31:0] write_size;
	logic        out_valid;
	logic        out_stall;
	logic [2:0]  kind;
	logic [31:0] range_offset;
	logic [31:0] range_size;
	logic        last;

	int failures;
	int pending;
	int beats_checked;
	int send_idle_pct;
	int recv_idle_pct;
	int cycle_count;
	int writes_sent;
	int flushes_sent;
	bit hold_req;
	bit hold_done;

	dirty_range_coalescer_unit #(
		.MAX_RANGES(TABLE_DEPTH)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.operation(operation),
		.write_offset(write_offset),
		.write_size(write_size),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.kind(kind),
		.range_offset(range_offset),
		.range_size(range_size),
		.last(last)
	);

	drc_checker #(
		.TABLE_DEPTH(TABLE_DEPTH),
		.FLUSH_OP(OP_FLUSH)
	) u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.operation(operation),
		.write_offset(write_offset),
		.write_size(write_size),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.kind(kind),
		.range_offset(range_offset),
		.range_size(range_size),
		.last(last),
		.failures(failures),
		.pending(pending),
		.beats_checked(beats_checked)
	);

	initial clk = 1'b0;
	always #1 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("FAIL dirty_range_coalescer_unit");
			$finish;
		end
	end

	initial begin
		out_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_req && !hold_done) begin
				hold_done = 1'b1;
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(negedge clk);
			end
			out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
		end
	end

	task automatic send_item(input logic op, input logic [31:0] off, input logic [31:0] sz);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		operation <= op;
		write_offset <= off;
		write_size <= sz;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		@(negedge clk);
		if (op == OP_FLUSH)
			flushes_sent++;
		else
			writes_sent++;
	endtask

	task automatic send_random_item();
		logic [31:0] base;
		logic [31:0] off;
		logic [31:0] sz;
		int pick;
		pick = $urandom_range(0, 99);
		off = $urandom();
		sz = $urandom();
		if (pick < 7) begin
			send_item(OP_FLUSH, off, sz);
		end else if (pick < 50) begin
			case ($urandom_range(0, 3))
				0: base = 32'h0000_0000;
				1: base = 32'h0001_0000;
				2: base = 32'h7FFF_F000;
				default: base = 32'hFFFF_E000;
			endcase
			off = base + $urandom_range(0, 32'h1FFF);
			sz = $urandom_range(0, 32'h80);
			send_item(OP_WRITE, off, sz);
		end else if (pick < 70) begin
			off = 32'h0100_0000 + $urandom_range(0, 47) * 32'h200;
			sz = $urandom_range(0, 32'h180);
			send_item(OP_WRITE, off, sz);
		end else if (pick < 82) begin
			sz = $urandom_range(0, 32'hFFFF);
			send_item(OP_WRITE, off, sz);
		end else if (pick < 90) begin
			sz = ~off + $urandom_range(0, 2);
			send_item(OP_WRITE, off, sz);
		end else begin
			send_item(OP_WRITE, off, sz);
		end
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		operation = OP_WRITE;
		write_offset = 32'h0;
		write_size = 32'h0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		send_item(OP_FLUSH, 32'h0, 32'h0);
		send_item(OP_WRITE, 32'h0000_0000, 32'h0000_0000);
		send_item(OP_WRITE, 32'h0000_0000, 32'hFFFF_FFFF);
		// The union with the full-length range would span the whole address space.
		send_item(OP_WRITE, 32'hFFFF_FFFF, 32'h0000_0001);
		send_item(OP_WRITE, 32'hFFFF_FFFF, 32'h0000_0002);
		send_item(OP_WRITE, 32'h8000_0000, 32'h8000_0001);
		send_item(OP_FLUSH, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_item(OP_WRITE, 32'hFFFF_FFFF, 32'h0000_0001);
		send_item(OP_WRITE, 32'hFFFF_FFFF, 32'h0000_0000);
		for (int i = 1; i < TABLE_DEPTH; i++)
			send_item(OP_WRITE, i * 32'h100, 32'h10);
		send_item(OP_WRITE, 32'h0000_5000, 32'h4);
		send_item(OP_WRITE, 32'h0000_0110, 32'h0);
		send_item(OP_FLUSH, 32'h0, 32'h0);

		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					send_idle_pct = 19;
					recv_idle_pct = 46;
				end
				1: begin
					send_idle_pct = 46;
					recv_idle_pct = 19;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
					hold_req = 1'b1;
				end
			endcase
			for (int n = 0; n < RANDOM_ITEMS / 3 + 1; n++)
				send_random_item();
		end
		in_valid <= 1'b0;

		wait (pending == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Covered %0d writes and %0d flushes under three idle mixes and a long hold-off.",
			writes_sent, flushes_sent);
		$display("Compared %0d result beats with the predicted range table.", beats_checked);
		if (failures == 0 && pending == 0)
			$display("PASS dirty_range_coalescer_unit");
		else
			$display("FAIL dirty_range_coalescer_unit");
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+design
design/drc_pkg.sv
design/drc_datapath.sv
design/drc_ctrl.sv
design/dirty_range_coalescer_unit.sv
tb/drc_checker.sv
tb/tb.sv
